>>> rtl/bale_pkg.sv
// ----------------------------------------------------------------------------
// bale_pkg: shared definitions for the bounded array list engine
// Sizes, command and status codes, and the structs passed between modules.
// ----------------------------------------------------------------------------
package bale_pkg;

   localparam int DEPTH    = 16;
   localparam int DATA_W   = 32;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int CNT_W    = ADDR_W + 1;
   localparam int CMD_W    = 3;
   localparam int CAP_W    = 5;
   localparam int STATUS_W = 2;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(DEPTH);

   typedef enum logic [CMD_W-1:0] {
      CMD_APPEND    = 3'd0,
      CMD_INSERT    = 3'd1,
      CMD_OVERWRITE = 3'd2,
      CMD_DELETE    = 3'd3,
      CMD_READ      = 3'd4,
      CMD_FIND      = 3'd5
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_OVERFLOW = 2'd1,
      ST_INVALID  = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   // Access request from the sequencer to the entry store.
   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [DATA_W-1:0] wdata;
      logic              re;
      logic [ADDR_W-1:0] raddr;
   } mem_req_type;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic [ADDR_W-1:0] position;
      logic [CNT_W-1:0]  count;
      logic              full_res;
      logic              empty_res;
      status_type        status;
   } rsp_type;

endpackage

>>> rtl/bale_chan_if.sv
// ----------------------------------------------------------------------------
// bale_chan_if: request and response channels
// Valid/ready channels carrying one list command and one command result.
// ----------------------------------------------------------------------------
interface bale_req_if;
   logic                                valid;
   logic                                ready;
   logic        [bale_pkg::CMD_W-1:0]   cmd;
   logic        [bale_pkg::ADDR_W-1:0]  index;
   logic signed [bale_pkg::DATA_W-1:0]  data;

   modport source (output valid, output cmd, output index, output data, input ready);
   modport sink   (input valid, input cmd, input index, input data, output ready);
endinterface

interface bale_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [bale_pkg::DATA_W-1:0]   value;
   logic        [bale_pkg::ADDR_W-1:0]   position;
   logic        [bale_pkg::CNT_W-1:0]    count;
   logic                                 full_res;
   logic                                 empty_res;
   logic        [bale_pkg::STATUS_W-1:0] status;

   modport source (output valid, output value, output position, output count,
                   output full_res, output empty_res, output status, input ready);
   modport sink   (input valid, input value, input position, input count,
                   input full_res, input empty_res, input status, output ready);
endinterface

>>> rtl/bale_mem.sv
// ----------------------------------------------------------------------------
// bale_mem: entry store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bale_mem (
   input  logic                         clock,
   input  bale_pkg::mem_req_type        mem_req,
   output logic [bale_pkg::DATA_W-1:0]  rd_data
);

   logic [bale_pkg::DATA_W-1:0] entries_ff [bale_pkg::DEPTH];
   logic [bale_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         entries_ff[mem_req.waddr] <= mem_req.wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.re) begin
         rd_data_ff <= entries_ff[mem_req.raddr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/bale_ctrl.sv
// ----------------------------------------------------------------------------
// bale_ctrl: command sequencer
// Decodes a request, walks the entry store for shifts and searches, and holds
// the result in an output register.
// ----------------------------------------------------------------------------
module bale_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   bale_req_if.sink                     req,
   bale_rsp_if.source                   rsp,
   input  logic [bale_pkg::CNT_W-1:0]   cap,
   output bale_pkg::mem_req_type        mem_req,
   input  logic [bale_pkg::DATA_W-1:0]  rd_data
);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_EXEC = 5'b00010,
      S_SCAN = 5'b00100,
      S_TAIL = 5'b01000,
      S_DONE = 5'b10000
   } state_type;

   state_type                    state_ff, state_in;
   logic [bale_pkg::CNT_W-1:0]   count_ff, count_in;
   bale_pkg::cmd_type            cmd_ff, cmd_in;
   logic [bale_pkg::ADDR_W-1:0]  idx_ff, idx_in;
   logic [bale_pkg::DATA_W-1:0]  data_ff, data_in;
   logic [bale_pkg::ADDR_W-1:0]  ptr_ff, ptr_in;
   logic [bale_pkg::ADDR_W-1:0]  last_ff, last_in;
   logic                         issue_ff, issue_in;
   logic                         pend_ff, pend_in;
   logic [bale_pkg::ADDR_W-1:0]  pend_addr_ff, pend_addr_in;
   logic [bale_pkg::DATA_W-1:0]  value_ff, value_in;
   logic [bale_pkg::ADDR_W-1:0]  position_ff, position_in;
   bale_pkg::status_type         status_ff, status_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   bale_pkg::rsp_type            rsp_data_ff, rsp_data_in;

   logic full;
   logic in_range;
   logic last_read;

   assign full      = (count_ff >= cap);
   assign in_range  = (bale_pkg::CNT_W'(idx_ff) < count_ff);
   assign last_read = pend_ff && (pend_addr_ff == last_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      cmd_in       = cmd_ff;
      idx_in       = idx_ff;
      data_in      = data_ff;
      ptr_in       = ptr_ff;
      last_in      = last_ff;
      issue_in     = issue_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      value_in     = value_ff;
      position_in  = position_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mem_req      = '0;

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               cmd_in      = bale_pkg::cmd_type'(req.cmd);
               idx_in      = req.index;
               data_in     = req.data;
               value_in    = '0;
               position_in = '0;
               status_in   = bale_pkg::ST_OK;
               state_in    = S_EXEC;
            end
         end

         S_EXEC: begin
            state_in = S_DONE;
            issue_in = 1'b0;
            pend_in  = 1'b0;
            case (cmd_ff)
               bale_pkg::CMD_APPEND: begin
                  if (full) begin
                     status_in = bale_pkg::ST_OVERFLOW;
                  end else begin
                     mem_req.we    = 1'b1;
                     mem_req.waddr = count_ff[bale_pkg::ADDR_W-1:0];
                     mem_req.wdata = data_ff;
                     count_in      = count_ff + 1'b1;
                  end
               end
               bale_pkg::CMD_INSERT: begin
                  if (!in_range) begin
                     status_in = bale_pkg::ST_INVALID;
                  end else if (full) begin
                     status_in = bale_pkg::ST_OVERFLOW;
                  end else begin
                     // Walk down from the top entry, moving each one up a slot.
                     ptr_in   = bale_pkg::ADDR_W'(count_ff - 1'b1);
                     last_in  = idx_ff;
                     issue_in = 1'b1;
                     state_in = S_SCAN;
                  end
               end
               bale_pkg::CMD_OVERWRITE: begin
                  if (!in_range) begin
                     status_in = bale_pkg::ST_INVALID;
                  end else begin
                     mem_req.we    = 1'b1;
                     mem_req.waddr = idx_ff;
                     mem_req.wdata = data_ff;
                  end
               end
               bale_pkg::CMD_DELETE: begin
                  if (!in_range) begin
                     status_in = bale_pkg::ST_INVALID;
                  end else begin
                     ptr_in   = idx_ff;
                     last_in  = bale_pkg::ADDR_W'(count_ff - 1'b1);
                     issue_in = 1'b1;
                     state_in = S_SCAN;
                  end
               end
               bale_pkg::CMD_READ: begin
                  if (!in_range) begin
                     status_in = bale_pkg::ST_INVALID;
                  end else begin
                     ptr_in   = idx_ff;
                     last_in  = idx_ff;
                     issue_in = 1'b1;
                     state_in = S_SCAN;
                  end
               end
               bale_pkg::CMD_FIND: begin
                  if (count_ff == '0) begin
                     status_in = bale_pkg::ST_NOTFOUND;
                  end else begin
                     ptr_in   = '0;
                     last_in  = bale_pkg::ADDR_W'(count_ff - 1'b1);
                     issue_in = 1'b1;
                     state_in = S_SCAN;
                  end
               end
               default: begin
               end
            endcase
         end

         S_SCAN: begin
            // Issue side: one read per cycle until the last address is out or the walk ends early.
            pend_in = issue_ff;
            if (issue_ff) begin
               mem_req.re   = 1'b1;
               mem_req.raddr = ptr_ff;
               pend_addr_in = ptr_ff;
               if (ptr_ff == last_ff) begin
                  issue_in = 1'b0;
               end else if (cmd_ff == bale_pkg::CMD_INSERT) begin
                  ptr_in = ptr_ff - 1'b1;
               end else begin
                  ptr_in = ptr_ff + 1'b1;
               end
            end

            // Data side: the word read in the previous cycle is used here. The
            // write always lands on the far side of the read pointer, so the
            // two ports never touch the same entry in one cycle.
            if (pend_ff) begin
               case (cmd_ff)
                  bale_pkg::CMD_DELETE: begin
                     if (pend_addr_ff == idx_ff) begin
                        value_in = rd_data;
                     end else begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = pend_addr_ff - 1'b1;
                        mem_req.wdata = rd_data;
                     end
                     if (last_read) begin
                        count_in = count_ff - 1'b1;
                        state_in = S_DONE;
                     end
                  end
                  bale_pkg::CMD_INSERT: begin
                     mem_req.we    = 1'b1;
                     mem_req.waddr = pend_addr_ff + 1'b1;
                     mem_req.wdata = rd_data;
                     if (last_read) begin
                        state_in = S_TAIL;
                     end
                  end
                  bale_pkg::CMD_READ: begin
                     value_in = rd_data;
                     state_in = S_DONE;
                  end
                  bale_pkg::CMD_FIND: begin
                     if (rd_data == data_ff) begin
                        position_in = pend_addr_ff;
                        state_in    = S_DONE;
                     end else if (last_read) begin
                        status_in = bale_pkg::ST_NOTFOUND;
                        state_in  = S_DONE;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
               if (state_in != S_SCAN) begin
                  issue_in = 1'b0;
                  pend_in  = 1'b0;
               end
            end
         end

         S_TAIL: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = idx_ff;
            mem_req.wdata = data_ff;
            count_in      = count_ff + 1'b1;
            state_in      = S_DONE;
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.value     = value_ff;
               rsp_data_in.position  = position_ff;
               rsp_data_in.count     = count_ff;
               rsp_data_in.full_res  = full;
               rsp_data_in.empty_res = (count_ff == '0);
               rsp_data_in.status    = status_ff;
               state_in              = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         issue_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         issue_ff     <= issue_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      idx_ff       <= idx_in;
      data_ff      <= data_in;
      ptr_ff       <= ptr_in;
      last_ff      <= last_in;
      pend_addr_ff <= pend_addr_in;
      value_ff     <= value_in;
      position_ff  <= position_in;
      status_ff    <= status_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign req.ready     = (state_ff == S_IDLE);
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.value     = rsp_data_ff.value;
   assign rsp.position  = rsp_data_ff.position;
   assign rsp.count     = rsp_data_ff.count;
   assign rsp.full_res  = rsp_data_ff.full_res;
   assign rsp.empty_res = rsp_data_ff.empty_res;
   assign rsp.status    = rsp_data_ff.status;

endmodule

>>> rtl/bounded_array_list_engine_top.sv
// ----------------------------------------------------------------------------
// bounded_array_list_engine_top: bounded ordered list of signed words
// Request channel in, response channel out, one capacity register.
// ----------------------------------------------------------------------------
// Each request on req_chan carries a command, an index and a data word; each
// one produces exactly one response on rsp_chan with the word read or removed,
// the match position, the count, the full and empty flags and a status code.
// The list is kept in a 16-entry single-write, single-read store with a
// registered read. Append and overwrite write the store directly and any
// request rejected by its checks goes straight to its response; read, delete,
// insert and find walk the list, one store read per entry walked, and insert
// writes the new word last. The next request can be taken in the cycle after
// the response is loaded. One request is worked on at a time; req_chan.ready
// is high whenever the sequencer is idle, also while the previous response
// still waits in the output register. If the receiver stalls, that register
// holds its response and a finished request waits until it is taken. Reset
// empties the list and sets the capacity to the full depth; the store itself
// is not cleared, since no entry is read before it is written. The capacity
// is written through csr_write_en and csr_write_data; the user must write it
// only while no request is in flight, which the block does not enforce. Zero
// acts as one and values above the depth act as the depth.
// ----------------------------------------------------------------------------
module bounded_array_list_engine_top (
   input  logic                        clock,
   input  logic                        reset,
   bale_req_if.sink                    req_chan,
   bale_rsp_if.source                  rsp_chan,
   input  logic                        csr_write_en,
   input  logic [bale_pkg::CAP_W-1:0]  csr_write_data
);

   logic [bale_pkg::CAP_W-1:0]  cap_ff, cap_in;
   logic [bale_pkg::CNT_W-1:0]  cap_eff;
   bale_pkg::mem_req_type       mem_req;
   logic [bale_pkg::DATA_W-1:0] rd_data;

   // Capacity register, raw as written.
   always_comb begin
      cap_in = cap_ff;
      if (csr_write_en) begin
         cap_in = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= bale_pkg::CAP_RESET;
      end else begin
         cap_ff <= cap_in;
      end
   end

   // Clamp the register into the range the store supports.
   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = bale_pkg::CNT_W'(1);
      end else if (32'(cap_ff) > bale_pkg::DEPTH) begin
         cap_eff = bale_pkg::CNT_W'(bale_pkg::DEPTH);
      end else begin
         cap_eff = bale_pkg::CNT_W'(cap_ff);
      end
   end

   bale_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .req     (req_chan),
      .rsp     (rsp_chan),
      .cap     (cap_eff),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   bale_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // Only one request is in the sequencer at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request accepted while another is in progress");

   // The reported count never exceeds the store depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (32'(rsp_chan.count) <= bale_pkg::DEPTH))
      else $error("count beyond depth");

   // An overflow is only ever reported against a full list.
   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.status == bale_pkg::ST_OVERFLOW)) |-> rsp_chan.full_res)
      else $error("overflow reported on a list that is not full");

   // A failed search reports position zero.
   a_notfound_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.status == bale_pkg::ST_NOTFOUND))
         |-> (rsp_chan.position == '0))
      else $error("failed search with nonzero position");

endmodule
